@@ hw/rtl/ecs_pkg.sv @@
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types, color tables and divider constants for the elevation shader.
// ----------------------------------------------------------------------------
package ecs_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_PALETTE_MODE = 2'd0;
	localparam logic [1:0] REG_SHADING_ENABLE = 2'd1;
	localparam logic [1:0] REG_SHADE_GAIN = 2'd2;

	// register reset values
	localparam logic RST_PALETTE_MODE = 1'b0;
	localparam logic RST_SHADING_ENABLE = 1'b1;
	localparam logic [15:0] RST_SHADE_GAIN = 16'd1707;

	// elevation coding
	localparam logic signed [19:0] INVALID_CODE = 20'sh80000;
	localparam logic signed [19:0] SHALLOW_LIMIT = -20'sd16;

	// banded ramp geometry
	localparam int BAND_M = 450;
	localparam int LEVEL_COUNT = 14;
	localparam int BAND_LIMIT_M = BAND_M * (LEVEL_COUNT - 1);

	// reciprocal constants: q = (n * recip) >> shift, exact over the used ranges
	localparam int BAND_SHIFT = 22;
	localparam logic [13:0] BAND_RECIP = 14'(((1 << BAND_SHIFT) + BAND_M - 1) / BAND_M);
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_ONE = 1 << RECIP_SHIFT;
	localparam logic [22:0] BAND_DIV_RECIP = 23'((RECIP_ONE + BAND_M - 1) / BAND_M);

	// hillshade
	localparam int SHADE_FRAC = 12;
	localparam int SHADE_LIMIT = 128;

	// breakpoint ramp
	localparam int BRK_COUNT = 8;
	localparam int BRK_TOP_Q4 = 5000 * 16;

	// palettes, rows past the last level are never selected for a visible color
	localparam logic [7:0] LAND_PAL [16][3] = '{
		'{8'd40, 8'd224, 8'd40}, '{8'd0, 8'd128, 8'd0}, '{8'd100, 8'd144, 8'd76},
		'{8'd204, 8'd170, 8'd136}, '{8'd136, 8'd100, 8'd70}, '{8'd128, 8'd128, 8'd128},
		'{8'd180, 8'd128, 8'd64}, '{8'd255, 8'd144, 8'd32}, '{8'd200, 8'd110, 8'd80},
		'{8'd160, 8'd80, 8'd160}, '{8'd144, 8'd40, 8'd128}, '{8'd128, 8'd128, 8'd128},
		'{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
		'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}
	};
	localparam logic [7:0] SEA_PAL [16][3] = '{
		'{8'd182, 8'd228, 8'd255}, '{8'd108, 8'd156, 8'd195}, '{8'd81, 8'd121, 8'd172},
		'{8'd43, 8'd90, 8'd142}, '{8'd0, 8'd0, 8'd160}, '{8'd0, 8'd128, 8'd128},
		'{8'd0, 8'd128, 8'd0}, '{8'd64, 8'd128, 8'd60}, '{8'd128, 8'd128, 8'd128},
		'{8'd144, 8'd64, 8'd144}, '{8'd160, 8'd0, 8'd160}, '{8'd128, 8'd128, 8'd0},
		'{8'd160, 8'd80, 8'd0}, '{8'd60, 8'd60, 8'd60},
		'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}
	};
	localparam logic [7:0] BRK_PAL [BRK_COUNT][3] = '{
		'{8'd221, 8'd188, 8'd140}, '{8'd156, 8'd173, 8'd132}, '{8'd189, 8'd189, 8'd148},
		'{8'd214, 8'd214, 8'd165}, '{8'd231, 8'd198, 8'd140}, '{8'd214, 8'd189, 8'd123},
		'{8'd189, 8'd189, 8'd189}, '{8'd125, 8'd125, 8'd125}
	};

	// breakpoints in Q.4 metres
	localparam logic [16:0] BRK_Q4 [BRK_COUNT] = '{
		17'd0, 17'd2400, 17'd6400, 17'd12800, 17'd25600, 17'd44800, 17'd64000, 17'd80000
	};
	// segment width in Q.4 metres, indexed by upper breakpoint
	localparam logic [14:0] BRK_DEN [BRK_COUNT] = '{
		15'd0, 15'd2400, 15'd4000, 15'd6400, 15'd12800, 15'd19200, 15'd19200, 15'd16000
	};
	// reciprocal of segment width in whole metres, numerator is pre-shifted by 4
	localparam logic [22:0] BRK_RECIP [BRK_COUNT] = '{
		23'd0,
		23'((RECIP_ONE + 149) / 150),
		23'((RECIP_ONE + 249) / 250),
		23'((RECIP_ONE + 399) / 400),
		23'((RECIP_ONE + 799) / 800),
		23'((RECIP_ONE + 1199) / 1200),
		23'((RECIP_ONE + 1199) / 1200),
		23'((RECIP_ONE + 999) / 1000)
	};

	// fixed colors
	localparam logic [7:0] COLOR_INVALID [3] = '{8'd255, 8'd0, 8'd0};
	localparam logic [7:0] COLOR_SEA_LEVEL [3] = '{8'd0, 8'd0, 8'hee};
	localparam logic [7:0] COLOR_COAST [3] = '{8'd34, 8'd34, 8'd153};
	localparam logic [7:0] COLOR_SHALLOW [3] = '{8'd221, 8'd178, 8'd125};

	// what kind of coloring a sample gets
	typedef enum logic [2:0] {
		KIND_INVALID,
		KIND_SEA_LEVEL,
		KIND_COAST,
		KIND_SHALLOW,
		KIND_LAND,
		KIND_SEA,
		KIND_BREAK
	} kind_t;

	// side-band control that travels with an item
	typedef struct packed {
		kind_t kind;
		logic  shade;
	} ctl_t;

endpackage

@@ hw/rtl/elevation_color_shader.sv @@
// ----------------------------------------------------------------------------
// elevation_color_shader
// Hypsometric color ramp with hillshade: one elevation sample in, one RGB
// pixel out, through a seven-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ---------            -------
//  input     in_valid/in_ready    elevation, right_elevation, has_right_neighbor
//  output    out_valid/out_ready  red, green, blue, is_invalid
//  config    cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
//  One item per cycle sustained while out_ready is high; an accepted item
//  passes through the seven register stages from s1 to s7 to out_valid.
//  arst_n clears all valid bits and loads the register defaults.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles close up under an output stall and in_ready falls only when all
//  seven stages hold an item.
//
module elevation_color_shader (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [19:0] elevation,
	input  logic signed [19:0] right_elevation,
	input  logic               has_right_neighbor,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               is_invalid
);

	// configuration registers
	logic        palette_mode_q;
	logic        shading_enable_q;
	logic [15:0] shade_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q <= ecs_pkg::RST_PALETTE_MODE;
			shading_enable_q <= ecs_pkg::RST_SHADING_ENABLE;
			shade_gain_q <= ecs_pkg::RST_SHADE_GAIN;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ecs_pkg::REG_PALETTE_MODE:   palette_mode_q <= cfg_data[0];
				ecs_pkg::REG_SHADING_ENABLE: shading_enable_q <= cfg_data[0];
				ecs_pkg::REG_SHADE_GAIN:     shade_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits and advance chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7 = !valid_s7 || out_ready;
	assign adv_s6 = !valid_s6 || adv_s7;
	assign adv_s5 = !valid_s5 || adv_s6;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign out_valid = valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
		end
	end

	// ---------------- stage 0: classify, magnitude, neighbor step ----------------
	ecs_pkg::ctl_t      ctl_in;
	logic [19:0]        mag_full;
	logic signed [20:0] diff_in;

	always_comb begin
		priority if (elevation == ecs_pkg::INVALID_CODE) begin
			ctl_in.kind = ecs_pkg::KIND_INVALID;
		end else if (elevation == 20'sd0) begin
			ctl_in.kind = palette_mode_q ? ecs_pkg::KIND_COAST : ecs_pkg::KIND_SEA_LEVEL;
		end else if (palette_mode_q && elevation < 0 && elevation > ecs_pkg::SHALLOW_LIMIT) begin
			ctl_in.kind = ecs_pkg::KIND_SHALLOW;
		end else if (elevation < 0) begin
			ctl_in.kind = ecs_pkg::KIND_SEA;
		end else if (palette_mode_q) begin
			ctl_in.kind = ecs_pkg::KIND_BREAK;
		end else begin
			ctl_in.kind = ecs_pkg::KIND_LAND;
		end
		ctl_in.shade = shading_enable_q && has_right_neighbor && elevation != 20'sd0
			&& elevation != ecs_pkg::INVALID_CODE;
		mag_full = elevation[19] ? 20'(-elevation) : 20'(elevation);
		diff_in = 21'(right_elevation) - 21'(elevation);
	end

	ecs_pkg::ctl_t      ctl_s1;
	logic [18:0]        mag_s1;
	logic signed [20:0] diff_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s1 <= ctl_in;
			mag_s1 <= mag_full[18:0];
			diff_s1 <= diff_in;
		end
	end

	// ---------------- stage 1: band, segment search, shade product ----------------
	logic [14:0]        m_c;
	logic [26:0]        band_prod;
	logic               band_oor;
	logic               brk_oor;
	logic [2:0]         seg_c;
	logic signed [37:0] shade_prod;

	always_comb begin
		m_c = mag_s1[18:4];
		band_prod = 27'(m_c[12:0]) * 27'(ecs_pkg::BAND_RECIP);
		band_oor = m_c >= 15'(ecs_pkg::BAND_LIMIT_M);
		brk_oor = mag_s1 > 19'(ecs_pkg::BRK_TOP_Q4);
		// first breakpoint at or above the height
		seg_c = 3'd0;
		for (int i = ecs_pkg::BRK_COUNT - 1; i >= 1; i--) begin
			if (mag_s1 <= 19'(ecs_pkg::BRK_Q4[i])) seg_c = 3'(i);
		end
		shade_prod = 38'(diff_s1) * 38'($signed({1'b0, shade_gain_q}));
	end

	ecs_pkg::ctl_t      ctl_s2;
	logic               oor_s2;
	logic [3:0]         band_s2;
	logic [2:0]         seg_s2;
	logic [12:0]        m_s2;
	logic [16:0]        mag_s2;
	logic signed [37:0] prod_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctl_s2 <= ctl_s1;
			oor_s2 <= (ctl_s1.kind == ecs_pkg::KIND_BREAK) ? brk_oor : band_oor;
			band_s2 <= band_prod[ecs_pkg::BAND_SHIFT +: 4];
			seg_s2 <= seg_c;
			m_s2 <= m_c[12:0];
			mag_s2 <= mag_s1[16:0];
			prod_s2 <= shade_prod;
		end
	end

	// ---------------- stage 2: offsets, palette fetch, shade term ----------------
	logic               is_brk_c2;
	logic               is_sea_c2;
	logic [3:0]         band_nx;
	logic [2:0]         seg_lo;
	logic [12:0]        frac_m;
	logic [14:0]        off_c;
	logic [7:0]         p0_c [3];
	logic [7:0]         p1_c [3];
	logic [14:0]        den_c;
	logic [22:0]        recip_c;
	logic signed [37:0] prod_adj;
	logic signed [37:0] shade_q;
	logic signed [8:0]  t_c;

	always_comb begin
		is_brk_c2 = ctl_s2.kind == ecs_pkg::KIND_BREAK;
		is_sea_c2 = ctl_s2.kind == ecs_pkg::KIND_SEA;
		band_nx = band_s2 + 4'd1;
		seg_lo = seg_s2 - 3'd1;
		frac_m = m_s2 - 13'(13'(band_s2) * 13'(ecs_pkg::BAND_M));
		off_c = is_brk_c2 ? 15'(mag_s2 - ecs_pkg::BRK_Q4[seg_lo]) : 15'(frac_m);
		den_c = is_brk_c2 ? ecs_pkg::BRK_DEN[seg_s2] : 15'(ecs_pkg::BAND_M);
		recip_c = is_brk_c2 ? ecs_pkg::BRK_RECIP[seg_s2] : ecs_pkg::BAND_DIV_RECIP;
		for (int k = 0; k < 3; k++) begin
			if (is_brk_c2) begin
				p0_c[k] = ecs_pkg::BRK_PAL[seg_lo][k];
				p1_c[k] = ecs_pkg::BRK_PAL[seg_s2][k];
			end else if (is_sea_c2) begin
				p0_c[k] = ecs_pkg::SEA_PAL[band_s2][k];
				p1_c[k] = ecs_pkg::SEA_PAL[band_nx][k];
			end else begin
				p0_c[k] = ecs_pkg::LAND_PAL[band_s2][k];
				p1_c[k] = ecs_pkg::LAND_PAL[band_nx][k];
			end
		end
		// shade term, truncated toward zero and clamped
		prod_adj = prod_s2 + (prod_s2[37] ? 38'sd4095 : 38'sd0);
		shade_q = prod_adj >>> ecs_pkg::SHADE_FRAC;
		if (shade_q > 38'(ecs_pkg::SHADE_LIMIT)) begin
			t_c = 9'(ecs_pkg::SHADE_LIMIT);
		end else if (shade_q < -38'(ecs_pkg::SHADE_LIMIT)) begin
			t_c = -9'(ecs_pkg::SHADE_LIMIT);
		end else begin
			t_c = shade_q[8:0];
		end
	end

	ecs_pkg::ctl_t     ctl_s3;
	logic              oor_s3;
	logic signed [8:0] t_s3;
	logic [14:0]       off_s3;
	logic [14:0]       den_s3;
	logic [22:0]       recip_s3;
	logic [7:0]        p0_s3 [3];
	logic signed [8:0] d_s3 [3];

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ctl_s3 <= ctl_s2;
			oor_s3 <= oor_s2;
			t_s3 <= t_c;
			off_s3 <= off_c;
			den_s3 <= den_c;
			recip_s3 <= recip_c;
			for (int k = 0; k < 3; k++) begin
				p0_s3[k] <= p0_c[k];
				d_s3[k] <= $signed({1'b0, p1_c[k]}) - $signed({1'b0, p0_c[k]});
			end
		end
	end

	// ---------------- stage 3: base and slope products ----------------
	ecs_pkg::ctl_t      ctl_s4;
	logic               oor_s4;
	logic signed [8:0]  t_s4;
	logic [22:0]        recip_s4;
	logic [22:0]        base_s4 [3];
	logic signed [24:0] slope_s4 [3];

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			ctl_s4 <= ctl_s3;
			oor_s4 <= oor_s3;
			t_s4 <= t_s3;
			recip_s4 <= recip_s3;
			for (int k = 0; k < 3; k++) begin
				base_s4[k] <= 23'(p0_s3[k]) * 23'(den_s3);
				slope_s4[k] <= 25'($signed({1'b0, off_s3})) * 25'(d_s3[k]);
			end
		end
	end

	// ---------------- stage 4: numerator sum ----------------
	logic signed [24:0] num_c [3];
	logic [18:0]        nsel_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num_c[k] = $signed({2'b00, base_s4[k]}) + slope_s4[k];
			// breakpoint widths are sixteen times their whole-metre divisors
			nsel_c[k] = (ctl_s4.kind == ecs_pkg::KIND_BREAK) ? num_c[k][22:4] : num_c[k][18:0];
		end
	end

	ecs_pkg::ctl_t     ctl_s5;
	logic              oor_s5;
	logic signed [8:0] t_s5;
	logic [22:0]       recip_s5;
	logic [18:0]       num_s5 [3];

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			ctl_s5 <= ctl_s4;
			oor_s5 <= oor_s4;
			t_s5 <= t_s4;
			recip_s5 <= recip_s4;
			for (int k = 0; k < 3; k++) num_s5[k] <= nsel_c[k];
		end
	end

	// ---------------- stage 5: reciprocal multiply ----------------
	logic [41:0] quot_prod [3];

	always_comb begin
		for (int k = 0; k < 3; k++) quot_prod[k] = 42'(num_s5[k]) * 42'(recip_s5);
	end

	ecs_pkg::ctl_t     ctl_s6;
	logic              oor_s6;
	logic signed [8:0] t_s6;
	logic [7:0]        ramp_s6 [3];

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			ctl_s6 <= ctl_s5;
			oor_s6 <= oor_s5;
			t_s6 <= t_s5;
			for (int k = 0; k < 3; k++) ramp_s6[k] <= quot_prod[k][ecs_pkg::RECIP_SHIFT +: 8];
		end
	end

	// ---------------- stage 6: fixed colors, shading, clamp ----------------
	logic [7:0]         base_c [3];
	logic signed [10:0] lit_c [3];
	logic [7:0]         pix_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unique case (ctl_s6.kind)
				ecs_pkg::KIND_INVALID:   base_c[k] = ecs_pkg::COLOR_INVALID[k];
				ecs_pkg::KIND_SEA_LEVEL: base_c[k] = ecs_pkg::COLOR_SEA_LEVEL[k];
				ecs_pkg::KIND_COAST:     base_c[k] = ecs_pkg::COLOR_COAST[k];
				ecs_pkg::KIND_SHALLOW:   base_c[k] = ecs_pkg::COLOR_SHALLOW[k];
				default:                 base_c[k] = oor_s6 ? 8'd0 : ramp_s6[k];
			endcase
			lit_c[k] = $signed({3'b000, base_c[k]}) + 11'(t_s6);
			if (!ctl_s6.shade) begin
				pix_c[k] = base_c[k];
			end else if (lit_c[k] < 11'sd0) begin
				pix_c[k] = 8'd0;
			end else if (lit_c[k] > 11'sd255) begin
				pix_c[k] = 8'd255;
			end else begin
				pix_c[k] = lit_c[k][7:0];
			end
		end
	end

	logic [7:0] red_s7, green_s7, blue_s7;
	logic       inv_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			red_s7 <= pix_c[0];
			green_s7 <= pix_c[1];
			blue_s7 <= pix_c[2];
			inv_s7 <= ctl_s6.kind == ecs_pkg::KIND_INVALID;
		end
	end

	assign red = red_s7;
	assign green = green_s7;
	assign blue = blue_s7;
	assign is_invalid = inv_s7;

	// ---------------- checks ----------------
	// input stalls only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& valid_s6 && valid_s7))
		else $error("input stalled with a bubble in the pipeline");

	// an invalid sample leaves as plain red
	a_invalid_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_invalid |-> red == 8'd255 && green == 8'd0 && blue == 8'd0)
		else $error("invalid sample not shown as red");

	// sea level, coast and invalid samples are never shaded
	a_no_shade_flat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && (ctl_s6.kind == ecs_pkg::KIND_INVALID
			|| ctl_s6.kind == ecs_pkg::KIND_SEA_LEVEL
			|| ctl_s6.kind == ecs_pkg::KIND_COAST) |-> !ctl_s6.shade)
		else $error("shading flagged on a flat or invalid sample");

	// shade term stays within its clamp
	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> t_s3 <= 9'sd128 && t_s3 >= -9'sd128)
		else $error("shade term out of range");

endmodule
